// ----- hdl/triangle_tangent_unit_defines.svh -----
// Assertion macros used by the RTL.
`ifndef TRIANGLE_TANGENT_UNIT_DEFINES_SVH
`define TRIANGLE_TANGENT_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define TTU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TTU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/ttu_pkg.sv -----
`default_nettype none
package ttu_pkg;
    localparam int CoordWidth = 32;
    localparam int PosW  = (CoordWidth < 32) ? CoordWidth : 32;
    localparam int EW    = PosW + 1;       // edge width
    localparam int TexW  = 16;
    localparam int DW    = TexW + 1;       // uv delta width
    localparam int RW    = EW + DW + 1;    // raw tangent / det width
    localparam int MagW  = 30;             // normalized magnitude
    localparam int SumW  = 2 * MagW + 2;   // sum of three squares
    localparam int RootW = SumW / 2;
    localparam int RemW  = RootW + 3;
    localparam int FracW = 14;
    localparam int NumW  = MagW + FracW + 1;
    localparam int DremW = RootW + 2;
    localparam int QW    = 16;
    localparam int CntW  = 6;
    localparam logic [QW-1:0] OneQ = QW'(1 << FracW);

    typedef enum logic [1:0] {
        PH_FIRST, PH_SECOND, PH_THIRD
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SIGN, S_NORM, S_SQ, S_SQRT, S_DIVSET, S_DIV, S_FIN, S_DONE
    } t_state;

    typedef struct packed {
        logic signed [EW-1:0] e1_x;
        logic signed [EW-1:0] e1_y;
        logic signed [EW-1:0] e1_z;
        logic signed [EW-1:0] d1_u;
        logic signed [EW-1:0] e2_x;
        logic signed [EW-1:0] e2_y;
        logic signed [EW-1:0] e2_z;
        logic signed [EW-1:0] d2_u;
        logic signed [DW-1:0] d1_v;
        logic signed [DW-1:0] d2_v;
    } t_operands;

    typedef struct packed {
        logic signed [QW-1:0] tx;
        logic signed [QW-1:0] ty;
        logic signed [QW-1:0] tz;
        logic                 deg;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;
endpackage
`default_nettype wire

// ----- hdl/ttu_core.sv -----
`default_nettype none
module ttu_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  ttu_pkg::t_operands     i_ops,
    input  wire                    i_ack,
    output ttu_pkg::t_core_stat    o_stat,
    output ttu_pkg::t_result       o_res
);
    localparam int RW = ttu_pkg::RW;
    localparam int EW = ttu_pkg::EW;
    localparam int DW = ttu_pkg::DW;
    localparam int MagW = ttu_pkg::MagW;
    localparam int SumW = ttu_pkg::SumW;
    localparam int RootW = ttu_pkg::RootW;
    localparam int RemW = ttu_pkg::RemW;
    localparam int NumW = ttu_pkg::NumW;
    localparam int DremW = ttu_pkg::DremW;
    localparam int QW = ttu_pkg::QW;
    localparam int CntW = ttu_pkg::CntW;

    ttu_pkg::t_state r_state, n_state;

    logic signed [EW-1:0]  r_a [4];
    logic signed [EW-1:0]  r_b [4];
    logic        [DW-1:0]  r_m2v, r_m1v;
    logic signed [RW-1:0]  r_acc [4];
    logic        [CntW-1:0] r_cnt;
    logic        [RW-1:0]  r_mag [3];
    logic                  r_neg [3];
    logic                  r_detz;
    logic        [MagW-1:0] r_sqm [3];
    logic        [SumW-1:0] r_sum;
    logic        [RemW-1:0] r_rem;
    logic        [RootW-1:0] r_root;
    logic        [NumW-1:0] r_num [3];
    logic        [DremW-1:0] r_drem [3];
    logic        [QW-1:0]  r_quo [3];
    ttu_pkg::t_result      r_res;

    // datapath helpers
    logic signed [RW-1:0]  mul_t [4];
    logic        [RW-1:0]  mag_or;
    logic                  norm_hi, norm_lo, degen;
    logic        [SumW-1:0] sq_add;
    logic        [RemW-1:0] sq_rs, sq_trial;
    logic        [DremW-1:0] dv_s [3];
    logic                  dv_ge [3];
    logic        [QW-1:0]  q_cl [3];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mul_t[k] = (r_m2v[DW-1] ? RW'(r_a[k]) : '0) - (r_m1v[DW-1] ? RW'(r_b[k]) : '0);
        end
        mag_or  = r_mag[0] | r_mag[1] | r_mag[2];
        norm_hi = |mag_or[RW-1:MagW];
        norm_lo = !mag_or[MagW-1];
        degen   = r_detz || (mag_or == '0);
        sq_add  = '0;
        for (int k = 0; k < 3; k++) begin
            sq_add = sq_add + (r_sqm[k][MagW-1] ? SumW'(r_mag[k][MagW-1:0]) : '0);
        end
        sq_rs    = {r_rem[RemW-3:0], r_sum[SumW-1 -: 2]};
        sq_trial = {1'b0, r_root, 2'b01};
        for (int k = 0; k < 3; k++) begin
            dv_s[k]  = {r_drem[k][DremW-2:0], r_num[k][NumW-1]};
            dv_ge[k] = dv_s[k] >= DremW'(r_root);
            q_cl[k]  = (r_quo[k] > ttu_pkg::OneQ) ? ttu_pkg::OneQ : r_quo[k];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ttu_pkg::S_IDLE:   if (i_start) n_state = ttu_pkg::S_MUL;
            ttu_pkg::S_MUL:    if (r_cnt == '0) n_state = ttu_pkg::S_SIGN;
            ttu_pkg::S_SIGN:   n_state = ttu_pkg::S_NORM;
            ttu_pkg::S_NORM: begin
                if (degen) n_state = ttu_pkg::S_DONE;
                else if (!norm_hi && !norm_lo) n_state = ttu_pkg::S_SQ;
            end
            ttu_pkg::S_SQ:     if (r_cnt == '0) n_state = ttu_pkg::S_SQRT;
            ttu_pkg::S_SQRT:   if (r_cnt == '0) n_state = ttu_pkg::S_DIVSET;
            ttu_pkg::S_DIVSET: n_state = ttu_pkg::S_DIV;
            ttu_pkg::S_DIV:    if (r_cnt == '0) n_state = ttu_pkg::S_FIN;
            ttu_pkg::S_FIN:    n_state = ttu_pkg::S_DONE;
            ttu_pkg::S_DONE:   if (i_ack) n_state = ttu_pkg::S_IDLE;
            default:           n_state = ttu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ttu_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ttu_pkg::S_IDLE: begin
                r_a[0] <= i_ops.e1_x; r_a[1] <= i_ops.e1_y;
                r_a[2] <= i_ops.e1_z; r_a[3] <= i_ops.d1_u;
                r_b[0] <= i_ops.e2_x; r_b[1] <= i_ops.e2_y;
                r_b[2] <= i_ops.e2_z; r_b[3] <= i_ops.d2_u;
                r_m2v  <= i_ops.d2_v;
                r_m1v  <= i_ops.d1_v;
                r_cnt  <= CntW'(DW - 1);
                for (int k = 0; k < 4; k++) r_acc[k] <= '0;
            end
            // MSB first shift-add; top bit carries negative weight
            ttu_pkg::S_MUL: begin
                for (int k = 0; k < 4; k++) begin
                    if (r_cnt == CntW'(DW - 1)) r_acc[k] <= -mul_t[k];
                    else                        r_acc[k] <= (r_acc[k] <<< 1) + mul_t[k];
                end
                r_m2v <= r_m2v << 1;
                r_m1v <= r_m1v << 1;
                r_cnt <= r_cnt - 1'b1;
            end
            ttu_pkg::S_SIGN: begin
                for (int k = 0; k < 3; k++) begin
                    r_mag[k] <= r_acc[k][RW-1] ? RW'(-r_acc[k]) : RW'(r_acc[k]);
                    r_neg[k] <= r_acc[k][RW-1] ^ r_acc[3][RW-1];
                end
                r_detz <= (r_acc[3] == '0);
            end
            // bring the largest magnitude into [2^29, 2^30)
            ttu_pkg::S_NORM: begin
                for (int k = 0; k < 3; k++) begin
                    if (norm_hi)      r_mag[k] <= r_mag[k] >> 1;
                    else if (norm_lo) r_mag[k] <= r_mag[k] << 1;
                    r_sqm[k] <= r_mag[k][MagW-1:0];
                end
                r_sum <= '0;
                r_cnt <= CntW'(MagW - 1);
                r_res <= '{tx: '0, ty: '0, tz: '0, deg: 1'b1};
            end
            ttu_pkg::S_SQ: begin
                r_sum <= (r_sum << 1) + sq_add;
                for (int k = 0; k < 3; k++) r_sqm[k] <= r_sqm[k] << 1;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= (r_cnt == '0) ? CntW'(RootW - 1) : r_cnt - 1'b1;
            end
            // two radicand bits per step
            ttu_pkg::S_SQRT: begin
                if (sq_rs >= sq_trial) begin
                    r_rem  <= sq_rs - sq_trial;
                    r_root <= {r_root[RootW-2:0], 1'b1};
                end else begin
                    r_rem  <= sq_rs;
                    r_root <= {r_root[RootW-2:0], 1'b0};
                end
                r_sum <= r_sum << 2;
                r_cnt <= r_cnt - 1'b1;
            end
            ttu_pkg::S_DIVSET: begin
                for (int k = 0; k < 3; k++) begin
                    r_num[k]  <= {1'b0, r_mag[k][MagW-1:0], ttu_pkg::FracW'(0)}
                                 + NumW'(r_root >> 1);
                    r_drem[k] <= '0;
                    r_quo[k]  <= '0;
                end
                r_cnt <= CntW'(NumW - 1);
            end
            // restoring division, one quotient bit per lane per step
            ttu_pkg::S_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    r_drem[k] <= dv_ge[k] ? dv_s[k] - DremW'(r_root) : dv_s[k];
                    r_quo[k]  <= {r_quo[k][QW-2:0], dv_ge[k]};
                    r_num[k]  <= r_num[k] << 1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
            ttu_pkg::S_FIN: begin
                r_res.tx  <= r_neg[0] ? -q_cl[0] : q_cl[0];
                r_res.ty  <= r_neg[1] ? -q_cl[1] : q_cl[1];
                r_res.tz  <= r_neg[2] ? -q_cl[2] : q_cl[2];
                r_res.deg <= 1'b0;
            end
            ttu_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // status
    always_comb begin
        o_stat.idle = (r_state == ttu_pkg::S_IDLE);
        o_stat.done = (r_state == ttu_pkg::S_DONE);
        o_res       = r_res;
    end
endmodule
`default_nettype wire

// ----- hdl/triangle_tangent_unit.sv -----
// Per-triangle tangent from vertex positions and texture coordinates.
// Input channel (i_in_valid / o_in_ready): one vertex per transfer, position
// in Q16.16 and uv in Q4.12. Every third vertex closes a triangle.
// Output channel (o_out_valid / i_out_ready): one unit tangent in Q1.14 per
// triangle, plus a degenerate flag (zero vector) when the uv determinant or
// the raw tangent is zero.
// The first two vertices of a triangle are always taken. The
// third starts a bit-serial sequencer: shift-add multiply, a sign step,
// one-bit normalize shifts, squaring, square root, a setup step, division
// and a finish step.
// A degenerate triangle skips the arithmetic after the sign step.
// While it runs the next triangle's first two vertices are still taken;
// its third vertex waits for the sequencer.
// A stalled receiver holds the result in the output register; the sequencer
// then waits with its next result until that register empties.
// Reset returns the vertex count to the first vertex and empties the
// output; stored vertices are not cleared.
`default_nettype none
`include "triangle_tangent_unit_defines.svh"
module triangle_tangent_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  signed [31:0]                i_pos_x,
    input  wire  signed [31:0]                i_pos_y,
    input  wire  signed [31:0]                i_pos_z,
    input  wire  signed [ttu_pkg::TexW-1:0]   i_tex_u,
    input  wire  signed [ttu_pkg::TexW-1:0]   i_tex_v,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic signed [ttu_pkg::QW-1:0]     o_tangent_x,
    output logic signed [ttu_pkg::QW-1:0]     o_tangent_y,
    output logic signed [ttu_pkg::QW-1:0]     o_tangent_z,
    output logic                              o_degenerate
);
    localparam int PosW = ttu_pkg::PosW;
    localparam int EW = ttu_pkg::EW;
    localparam int TexW = ttu_pkg::TexW;
    localparam int DW = ttu_pkg::DW;

    ttu_pkg::t_phase       r_phase;
    logic [PosW-1:0]       r_p0 [3];
    logic [PosW-1:0]       r_p1 [3];
    logic [TexW-1:0]       r_t0 [2];
    logic [TexW-1:0]       r_t1 [2];
    ttu_pkg::t_result      r_out;
    logic                  r_out_valid;

    logic                  in_xfer, start, ack;
    logic signed [EW-1:0]  p0s [3];
    logic signed [EW-1:0]  p1s [3];
    logic signed [EW-1:0]  p2s [3];
    logic signed [DW-1:0]  t0s [2];
    logic signed [DW-1:0]  t1s [2];
    logic signed [DW-1:0]  t2s [2];
    ttu_pkg::t_operands    ops;
    ttu_pkg::t_core_stat   stat;
    ttu_pkg::t_result      res;
    logic                  tan_zero, tan_in_range;

    // handshake
    assign o_in_ready = (r_phase != ttu_pkg::PH_THIRD) || stat.idle;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign start      = in_xfer && (r_phase == ttu_pkg::PH_THIRD);
    assign ack        = !r_out_valid || i_out_ready;

    // sign-extend and form edges and uv deltas
    always_comb begin
        p2s[0] = EW'(signed'(i_pos_x[PosW-1:0]));
        p2s[1] = EW'(signed'(i_pos_y[PosW-1:0]));
        p2s[2] = EW'(signed'(i_pos_z[PosW-1:0]));
        for (int k = 0; k < 3; k++) begin
            p0s[k] = EW'(signed'(r_p0[k]));
            p1s[k] = EW'(signed'(r_p1[k]));
        end
        t2s[0] = DW'(i_tex_u);
        t2s[1] = DW'(i_tex_v);
        for (int k = 0; k < 2; k++) begin
            t0s[k] = DW'(signed'(r_t0[k]));
            t1s[k] = DW'(signed'(r_t1[k]));
        end
        ops.e1_x = p1s[0] - p0s[0];
        ops.e1_y = p1s[1] - p0s[1];
        ops.e1_z = p1s[2] - p0s[2];
        ops.e2_x = p2s[0] - p0s[0];
        ops.e2_y = p2s[1] - p0s[1];
        ops.e2_z = p2s[2] - p0s[2];
        ops.d1_u = EW'(DW'(t1s[0] - t0s[0]));
        ops.d2_u = EW'(DW'(t2s[0] - t0s[0]));
        ops.d1_v = t1s[1] - t0s[1];
        ops.d2_v = t2s[1] - t0s[1];
    end

    // vertex count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ttu_pkg::PH_FIRST;
        end else if (in_xfer) begin
            unique case (r_phase)
                ttu_pkg::PH_FIRST:  r_phase <= ttu_pkg::PH_SECOND;
                ttu_pkg::PH_SECOND: r_phase <= ttu_pkg::PH_THIRD;
                default:            r_phase <= ttu_pkg::PH_FIRST;
            endcase
        end
    end

    // first and second vertex store
    always_ff @(posedge i_clk) begin
        if (in_xfer && r_phase == ttu_pkg::PH_SECOND) begin
            r_p1[0] <= i_pos_x[PosW-1:0];
            r_p1[1] <= i_pos_y[PosW-1:0];
            r_p1[2] <= i_pos_z[PosW-1:0];
            r_t1[0] <= i_tex_u;
            r_t1[1] <= i_tex_v;
        end else if (in_xfer && r_phase != ttu_pkg::PH_THIRD) begin
            r_p0[0] <= i_pos_x[PosW-1:0];
            r_p0[1] <= i_pos_y[PosW-1:0];
            r_p0[2] <= i_pos_z[PosW-1:0];
            r_t0[0] <= i_tex_u;
            r_t0[1] <= i_tex_v;
        end
    end

    ttu_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_ops   (ops),
        .i_ack   (ack),
        .o_stat  (stat),
        .o_res   (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done && ack) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done && ack) r_out <= res;
    end

    assign o_out_valid  = r_out_valid;
    assign o_tangent_x  = r_out.tx;
    assign o_tangent_y  = r_out.ty;
    assign o_tangent_z  = r_out.tz;
    assign o_degenerate = r_out.deg;

    // terms for the checks
    assign tan_zero = (o_tangent_x == '0) && (o_tangent_y == '0) && (o_tangent_z == '0);
    assign tan_in_range = (o_tangent_x <= 16'sd16384) && (o_tangent_x >= -16'sd16384)
                       && (o_tangent_y <= 16'sd16384) && (o_tangent_y >= -16'sd16384)
                       && (o_tangent_z <= 16'sd16384) && (o_tangent_z >= -16'sd16384);

    // checks
    `TTU_ASSERT(a_start_busy, start |=> !stat.idle, "sequencer did not start on third vertex")
    `TTU_ASSERT(a_deg_zero, (o_out_valid && o_degenerate) |-> tan_zero, "degenerate not zero")
    `TTU_ASSERT(a_range, o_out_valid |-> tan_in_range, "tangent out of range")
    `TTU_ASSERT_ALWAYS(a_reset_empty, !$past(i_rst_n) |-> !o_out_valid, "output valid after reset")
endmodule
`default_nettype wire

// ----- bench/triangle_tangent_unit_test.sv -----
`default_nettype none
module triangle_tangent_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 400;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] tu, tv;
    } t_vertex;

    typedef struct {
        logic signed [15:0] tx, ty, tz;
        logic               deg;
    } t_tangent;

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [15:0] i_tex_u, i_tex_v;
    logic o_out_valid, i_out_ready;
    logic signed [15:0] o_tangent_x, o_tangent_y, o_tangent_z;
    logic o_degenerate;

    triangle_tangent_unit DUT (.*);

    t_vertex  vertex_queue[$];
    t_tangent tangent_queue[$];
    t_vertex  corner0, corner1;
    ttu_pkg::t_phase corner_phase;
    int fail_count;
    int stall_cycles;
    int sender_idle_pct, receiver_stall_pct;

    // exact fixed-point tangent of one triangle
    function automatic t_tangent triangle_tangent(t_vertex a, t_vertex b, t_vertex c);
        longint e1[3], e2[3], raw[3], d1u, d1v, d2u, d2v, det;
        longint unsigned mag[3], mx, sum, len, r, bit_, x, q;
        t_tangent t;
        e1[0] = longint'(b.px) - a.px; e2[0] = longint'(c.px) - a.px;
        e1[1] = longint'(b.py) - a.py; e2[1] = longint'(c.py) - a.py;
        e1[2] = longint'(b.pz) - a.pz; e2[2] = longint'(c.pz) - a.pz;
        d1u = longint'(b.tu) - a.tu; d1v = longint'(b.tv) - a.tv;
        d2u = longint'(c.tu) - a.tu; d2v = longint'(c.tv) - a.tv;
        det = d1u * d2v - d2u * d1v;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            raw[i] = d2v * e1[i] - d1v * e2[i];
            if (det < 0) raw[i] = -raw[i];
            mag[i] = raw[i] < 0 ? longint'(-raw[i]) : raw[i];
            if (mag[i] > mx) mx = mag[i];
        end
        t = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        if (det == 0 || mx == 0) return t;
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        // integer square root
        x = sum; r = 0; bit_ = 64'd1 << 62;
        while (bit_ > x) bit_ >>= 2;
        while (bit_ != 0) begin
            if (x >= r + bit_) begin
                x -= r + bit_;
                r = (r >> 1) + bit_;
            end else begin
                r >>= 1;
            end
            bit_ >>= 2;
        end
        len = r;
        t.deg = 1'b0;
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + len / 2) / len;
            if (q > 16384) q = 16384;
            if (i == 0) t.tx = raw[i] < 0 ? -16'(q) : 16'(q);
            if (i == 1) t.ty = raw[i] < 0 ? -16'(q) : 16'(q);
            if (i == 2) t.tz = raw[i] < 0 ? -16'(q) : 16'(q);
        end
        return t;
    endfunction

    function automatic t_vertex mk_vertex(int px, int py, int pz, int tu, int tv);
        t_vertex v;
        v.px = px; v.py = py; v.pz = pz; v.tu = 16'(tu); v.tv = 16'(tv);
        return v;
    endfunction

    function automatic logic signed [31:0] rand_pos(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed(32'($urandom_range(0, 8192))) - 4096;
            default: return $signed(32'($urandom_range(0, 2000000))) - 1000000;
        endcase
    endfunction

    function automatic t_vertex rand_vertex(t_vertex base, int mode);
        t_vertex v;
        if (mode == 0) begin
            v.px = $urandom; v.py = $urandom; v.pz = $urandom;
            v.tu = $urandom; v.tv = $urandom;
        end else begin
            v.px = base.px + rand_pos(mode);
            v.py = base.py + rand_pos(mode);
            v.pz = base.pz + rand_pos(mode);
            v.tu = base.tu + 16'($urandom_range(0, 2048)) - 16'sd1024;
            v.tv = base.tv + 16'($urandom_range(0, 2048)) - 16'sd1024;
        end
        return v;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // driver: the queue head is the item on the bus until its transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                void'(vertex_queue.pop_front());
            end
            if ((!i_in_valid || o_in_ready) && vertex_queue.size() > 0
                    && $urandom_range(0, 99) >= sender_idle_pct) begin
                t_vertex v;
                v = vertex_queue[0];
                i_in_valid <= 1'b1;
                i_pos_x <= v.px; i_pos_y <= v.py; i_pos_z <= v.pz;
                i_tex_u <= v.tu; i_tex_v <= v.tv;
            end else if (i_in_valid && o_in_ready) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // input monitor: builds expected tangents from accepted vertices
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            corner_phase <= ttu_pkg::PH_FIRST;
        end else if (i_in_valid && o_in_ready) begin
            t_vertex v;
            v = mk_vertex(i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v);
            case (corner_phase)
                ttu_pkg::PH_FIRST: begin
                    corner0 <= v;
                    corner_phase <= ttu_pkg::PH_SECOND;
                end
                ttu_pkg::PH_SECOND: begin
                    corner1 <= v;
                    corner_phase <= ttu_pkg::PH_THIRD;
                end
                default: begin
                    tangent_queue.push_back(triangle_tangent(corner0, corner1, v));
                    corner_phase <= ttu_pkg::PH_FIRST;
                end
            endcase
        end
    end

    // output monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(0, 99) >= receiver_stall_pct;
            if (o_out_valid && i_out_ready) begin
                if (tangent_queue.size() == 0) begin
                    $error("unexpected tangent transfer");
                    fail_count++;
                end else begin
                    t_tangent e;
                    e = tangent_queue.pop_front();
                    if (o_tangent_x !== e.tx) begin
                        $error("tangent_x expected %0d got %0d", e.tx, o_tangent_x);
                        fail_count++;
                    end
                    if (o_tangent_y !== e.ty) begin
                        $error("tangent_y expected %0d got %0d", e.ty, o_tangent_y);
                        fail_count++;
                    end
                    if (o_tangent_z !== e.tz) begin
                        $error("tangent_z expected %0d got %0d", e.tz, o_tangent_z);
                        fail_count++;
                    end
                    if (o_degenerate !== e.deg) begin
                        $error("degenerate expected %0d got %0d", e.deg, o_degenerate);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (vertex_queue.size() != 0 || tangent_queue.size() != 0) begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WatchdogLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic add_triangle(t_vertex a, t_vertex b, t_vertex c);
        vertex_queue.push_back(a);
        vertex_queue.push_back(b);
        vertex_queue.push_back(c);
    endtask

    task automatic wait_drained();
        while (vertex_queue.size() != 0 || i_in_valid || tangent_queue.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_vertex a, b, c;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_out_ready = 1'b0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0; i_tex_u = '0; i_tex_v = '0;
        fail_count = 0; stall_cycles = 0;
        sender_idle_pct = 0; receiver_stall_pct = 0;
        corner_phase = ttu_pkg::PH_FIRST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed triangles: plain, negative det, zero det, zero vector, extremes
        add_triangle(mk_vertex(0, 0, 0, 0, 0), mk_vertex(65536, 0, 0, 4096, 0),
                     mk_vertex(0, 65536, 0, 0, 4096));
        add_triangle(mk_vertex(0, 0, 0, 0, 0), mk_vertex(65536, 0, 0, 4096, 0),
                     mk_vertex(0, 65536, 0, 0, -4096));
        add_triangle(mk_vertex(5, 6, 7, 100, 100), mk_vertex(9, 9, 9, 100, 100),
                     mk_vertex(1, 2, 3, 100, 100));
        add_triangle(mk_vertex(3, 3, 3, 0, 0), mk_vertex(3, 3, 3, 4096, 0),
                     mk_vertex(3, 3, 3, 0, 4096));
        add_triangle(mk_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, -32768, 32767),
                     mk_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32767, -32768),
                     mk_vertex(32'h7fffffff, 32'h7fffffff, 32'h80000000, -32768, -32768));
        add_triangle(mk_vertex(-1, -1, -1, -1, -1), mk_vertex(1, 0, 0, 1, 0),
                     mk_vertex(0, 1, 0, 0, 1));
        add_triangle(mk_vertex(0, 0, 0, 0, 0), mk_vertex(0, 0, 1, 1, 0),
                     mk_vertex(0, 0, -1, 0, 1));
        wait_drained();

        // random phases with different idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = (ph == 1 || ph == 3) ? (ph == 3 ? 14 : 88) : 0;
            receiver_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 14 : 88) : 0;
            for (int n = 0; n < 145; n++) begin
                int mode;
                mode = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2);
                a = rand_vertex(a, 0);
                if ($urandom_range(0, 3) == 0) a.px = rand_pos(1);
                b = rand_vertex(a, mode);
                c = rand_vertex(a, mode);
                if ($urandom_range(0, 19) == 0) c = b;
                add_triangle(a, b, c);
            end
            wait_drained();
        end

        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && tangent_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
